@@ sv/mrpt_pkg.sv @@
// mrpt_pkg: shared types and constants for the mask region pixel tint block.
// No dependencies; compile this file first.
`timescale 1ns / 1ps
`default_nettype none

package mrpt_pkg;

   localparam int CHAN_W    = 8;
   localparam int TINT_W    = 3 * CHAN_W;
   localparam int NUM_TINTS = 4;
   localparam int IDX_W     = $clog2(NUM_TINTS);
   localparam int CSR_AW    = IDX_W + 2;
   localparam int CSR_DW    = 32;

   localparam logic [TINT_W-1:0] TINT_RESET = {TINT_W{1'b1}};

   // Register index within the CSR map (byte address = 4 * index).
   typedef enum logic [IDX_W-1:0] {
      REG_HEAD = 2'd0,
      REG_BODY = 2'd1,
      REG_LEGS = 2'd2,
      REG_FEET = 2'd3
   } reg_idx_type;

   typedef logic [NUM_TINTS-1:0][TINT_W-1:0] tint_set_type;

   typedef struct packed {
      logic [CHAN_W-1:0] pix_red;
      logic [CHAN_W-1:0] pix_green;
      logic [CHAN_W-1:0] pix_blue;
      logic [CHAN_W-1:0] mask_red;
      logic [CHAN_W-1:0] mask_green;
      logic [CHAN_W-1:0] mask_blue;
      logic              last_in;
   } pix_beat_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic              last_out;
   } rsp_beat_type;

endpackage

`default_nettype wire

@@ sv/mrpt_if.sv @@
// mrpt_req_if / mrpt_rsp_if: valid/ready channels for pixel and result beats.
// Depends on mrpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mrpt_req_if import mrpt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] pix_red;
   logic [CHAN_W-1:0] pix_green;
   logic [CHAN_W-1:0] pix_blue;
   logic [CHAN_W-1:0] mask_red;
   logic [CHAN_W-1:0] mask_green;
   logic [CHAN_W-1:0] mask_blue;
   logic              last_in;

   modport source (
      output valid, pix_red, pix_green, pix_blue, mask_red, mask_green, mask_blue,
             last_in,
      input  ready
   );
   modport sink (
      input  valid, pix_red, pix_green, pix_blue, mask_red, mask_green, mask_blue,
             last_in,
      output ready
   );
endinterface

interface mrpt_rsp_if import mrpt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] out_red;
   logic [CHAN_W-1:0] out_green;
   logic [CHAN_W-1:0] out_blue;
   logic              last_out;

   modport source (
      output valid, out_red, out_green, out_blue, last_out,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, last_out,
      output ready
   );
endinterface

`default_nettype wire

@@ sv/mrpt_csr.sv @@
// mrpt_csr: APB-style register file holding the four region tint colors.
// Depends on mrpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrpt_csr import mrpt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output tint_set_type      tints
);

   tint_set_type      tint_ff;
   tint_set_type      tint_in;
   logic [IDX_W-1:0]  reg_idx;
   logic              wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_AW-1:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      tint_in = tint_ff;
      if (wr_en) begin
         case (reg_idx_type'(reg_idx))
            REG_HEAD: tint_in[REG_HEAD] = pwdata[TINT_W-1:0];
            REG_BODY: tint_in[REG_BODY] = pwdata[TINT_W-1:0];
            REG_LEGS: tint_in[REG_LEGS] = pwdata[TINT_W-1:0];
            REG_FEET: tint_in[REG_FEET] = pwdata[TINT_W-1:0];
            default:  tint_in = tint_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_ff <= {NUM_TINTS{TINT_RESET}};
      end else begin
         tint_ff <= tint_in;
      end
   end

   assign prdata = {{(CSR_DW-TINT_W){1'b0}}, tint_ff[reg_idx]};
   assign tints  = tint_ff;

endmodule

`default_nettype wire

@@ sv/mrpt_tint.sv @@
// mrpt_tint: region decode and per-channel floor(c * t / 255) scaling.
// Depends on mrpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrpt_tint import mrpt_pkg::*; (
   input  pix_beat_type pix,
   input  tint_set_type tints,
   output rsp_beat_type rsp
);

   // floor(p / 255) for p below 2^16: (p + 1 + (p >> 8)) >> 8.
   function automatic logic [CHAN_W-1:0] scale_chan(
      input logic [CHAN_W-1:0] c,
      input logic [CHAN_W-1:0] t
   );
      logic [2*CHAN_W-1:0] prod;
      logic [2*CHAN_W:0]   sum;
      prod = c * t;
      sum  = {1'b0, prod} + {{(2*CHAN_W){1'b0}}, 1'b1}
             + {{(CHAN_W+1){1'b0}}, prod[2*CHAN_W-1:CHAN_W]};
      return sum[2*CHAN_W-1:CHAN_W];
   endfunction

   logic              m_r, m_g, m_b;
   logic              hit;
   logic [TINT_W-1:0] tint;

   assign m_r = |pix.mask_red;
   assign m_g = |pix.mask_green;
   assign m_b = |pix.mask_blue;

   always_comb begin
      hit  = 1'b1;
      case ({m_r, m_g, m_b})
         3'b110:  tint = tints[REG_HEAD];
         3'b100:  tint = tints[REG_BODY];
         3'b010:  tint = tints[REG_LEGS];
         3'b001:  tint = tints[REG_FEET];
         default: begin
            hit  = 1'b0;
            tint = TINT_RESET;
         end
      endcase
   end

   always_comb begin
      rsp.last_out = pix.last_in;
      if (hit) begin
         rsp.out_red   = scale_chan(pix.pix_red,   tint[3*CHAN_W-1:2*CHAN_W]);
         rsp.out_green = scale_chan(pix.pix_green, tint[2*CHAN_W-1:CHAN_W]);
         rsp.out_blue  = scale_chan(pix.pix_blue,  tint[CHAN_W-1:0]);
      end else begin
         rsp.out_red   = pix.pix_red;
         rsp.out_green = pix.pix_green;
         rsp.out_blue  = pix.pix_blue;
      end
   end

endmodule

`default_nettype wire

@@ sv/mask_region_pixel_tint.sv @@
// mask_region_pixel_tint: top level; input register, tint datapath, result register.
// Depends on mrpt_pkg, mrpt_if, mrpt_csr and mrpt_tint.
//
//   channel   dir   handshake            beat contents
//   req_bus   in    valid / ready        pix_red/green/blue, mask_red/green/blue, last_in
//   rsp_bus   out   valid / ready        out_red/green/blue, last_out
//   csr       in    APB psel / penable   four 24-bit tints, 0xRRGGBB at 4 * index
//
// One pixel per clock sustained while rsp_bus does not stall. An accepted beat
// is held in the input register, then in the result register, and leaves from
// there. The two registers sit around a single 8x8 multiply-and-scale per
// channel.
// Reset is synchronous, active high: both stages empty, all tints 0xFFFFFF.
// A stall on rsp_bus holds the result register; the input register keeps
// taking beats until it also holds one, then req_bus.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module mask_region_pixel_tint import mrpt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   mrpt_req_if.sink          req_bus,
   mrpt_rsp_if.source        rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   tint_set_type tints;

   pix_beat_type pix_ff;
   pix_beat_type pix_in;
   logic         pix_vld_ff;
   logic         pix_vld_in;

   rsp_beat_type rsp_ff;
   rsp_beat_type rsp_in;
   rsp_beat_type rsp_calc;
   logic         rsp_vld_ff;
   logic         rsp_vld_in;

   logic         req_ready;
   logic         mid_ready;

   mrpt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .tints   (tints)
   );

   // Result stage frees up when empty or when its beat is being taken.
   assign mid_ready = !rsp_vld_ff || rsp_bus.ready;
   // Input stage takes a beat when empty or when it moves forward this cycle.
   assign req_ready = !pix_vld_ff || mid_ready;
   assign req_bus.ready = req_ready;

   // Input register: load on accept, drop its valid once it advances.
   always_comb begin
      pix_in     = pix_ff;
      pix_vld_in = pix_vld_ff;
      if (req_ready) begin
         pix_vld_in = req_bus.valid;
         if (req_bus.valid) begin
            pix_in.pix_red    = req_bus.pix_red;
            pix_in.pix_green  = req_bus.pix_green;
            pix_in.pix_blue   = req_bus.pix_blue;
            pix_in.mask_red   = req_bus.mask_red;
            pix_in.mask_green = req_bus.mask_green;
            pix_in.mask_blue  = req_bus.mask_blue;
            pix_in.last_in    = req_bus.last_in;
         end
      end
   end

   mrpt_tint u_tint (
      .pix   (pix_ff),
      .tints (tints),
      .rsp   (rsp_calc)
   );

   // Result register: advance whenever the downstream side allows it.
   always_comb begin
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff;
      if (mid_ready) begin
         rsp_vld_in = pix_vld_ff;
         if (pix_vld_ff) begin
            rsp_in = rsp_calc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         pix_vld_ff <= pix_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid     = rsp_vld_ff;
   assign rsp_bus.out_red   = rsp_ff.out_red;
   assign rsp_bus.out_green = rsp_ff.out_green;
   assign rsp_bus.out_blue  = rsp_ff.out_blue;
   assign rsp_bus.last_out  = rsp_ff.last_out;

endmodule

`default_nettype wire

@@ sv/mrpt_checker.sv @@
// mrpt_checker: port-level assertions for mask_region_pixel_tint, plus its bind.
// Depends on mrpt_pkg and the top level.
`timescale 1ns / 1ps
`default_nettype none

module mrpt_checker import mrpt_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] out_red,
   input logic [CHAN_W-1:0] out_green,
   input logic [CHAN_W-1:0] out_blue,
   input logic              last_out
);

   // Result stage empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   // With no result pending the pipeline has room for a new beat.
   a_ready_when_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input not ready while result stage empty");

   // After an accepted beat, the result side shows a valid beat.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##2 rsp_valid)
      else $error("accepted beat did not reach result stage");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(out_red) && $stable(out_green)
          && $stable(out_blue) && $stable(last_out)))
      else $error("stalled result beat changed");

endmodule

bind mask_region_pixel_tint mrpt_checker u_mrpt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .out_red   (rsp_bus.out_red),
   .out_green (rsp_bus.out_green),
   .out_blue  (rsp_bus.out_blue),
   .last_out  (rsp_bus.last_out)
);

`default_nettype wire
